// ===== hw/rtl/emru_pkg.sv =====
// ----------------------------------------------------------------------------
// emru_pkg
// Shared types, register map constants and helpers for the mailbox reply unit.
// ----------------------------------------------------------------------------
package emru_pkg;

  // Window sizes
  localparam int TX_WORDS = 8;
  localparam int RX_WORDS = 8;
  localparam int TX_IDX_W = (TX_WORDS > 1) ? $clog2(TX_WORDS) : 1;
  localparam int RX_IDX_W = $clog2(RX_WORDS);

  localparam int ADDR_W = 12;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 4;
  localparam int N_CTRL = 6;
  localparam int CTRL_IDX_W = $clog2(N_CTRL);

  // Request types
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Register map
  localparam logic [ADDR_W-1:0] ADDR_VERSION = 12'h000;
  localparam logic [ADDR_W-1:0] ADDR_SIZES   = 12'h004;
  localparam logic [ADDR_W-1:0] ADDR_TSR     = 12'h124;
  localparam logic [ADDR_W-1:0] ADDR_RSR     = 12'h12C;
  localparam logic [ADDR_W-1:0] TX_BASE      = 12'h200;
  localparam logic [ADDR_W-1:0] RX_BASE      = 12'h280;
  localparam logic [ADDR_W-1:0] TX_END       = ADDR_W'(32'h200 + 4 * TX_WORDS);
  localparam logic [ADDR_W-1:0] RX_END       = ADDR_W'(32'h280 + 4 * RX_WORDS);

  // Control registers, highest index first (index 0 is 12'h008)
  localparam logic [N_CTRL-1:0][ADDR_W-1:0] CTRL_ADDR =
    {12'h128, 12'h120, 12'h114, 12'h110, 12'h100, 12'h008};

  // Read-only words
  localparam logic [DATA_W-1:0] VER_WORD   = 32'h0000_0100;
  localparam logic [DATA_W-1:0] SIZES_WORD = DATA_W'((RX_WORDS << 8) | TX_WORDS);
  localparam logic [DATA_W-1:0] TSR_WORD   = DATA_W'((64'd1 << TX_WORDS) - 64'd1);

  // Reply codes
  localparam logic [7:0] HDR_TAG = 8'hE1;
  localparam logic [7:0] ST_OK   = 8'hD6;
  localparam logic [7:0] ST_FAIL = 8'h29;

  // Known commands
  localparam logic [7:0] CMD_BASIC  = 8'h01;
  localparam logic [7:0] CMD_GRP_LO = 8'h10;
  localparam logic [7:0] CMD_GRP_HI = 8'h13;
  localparam logic [7:0] CMD_C4     = 8'hC4;
  localparam logic [7:0] CMD_C5     = 8'hC5;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] write_data;
  } emru_req_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] read_data;
  } emru_rsp_t;

  function automatic logic cmd_known(input logic [7:0] c);
    return (c == CMD_BASIC) || (c inside {[CMD_GRP_LO:CMD_GRP_HI]}) ||
           (c == CMD_C4) || (c == CMD_C5);
  endfunction

endpackage

// ===== hw/rtl/emru_if.sv =====
// ----------------------------------------------------------------------------
// emru interfaces
// Valid/ready channels for bus requests, read responses and configuration.
// ----------------------------------------------------------------------------
interface emru_req_if;
  import emru_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ADDR_W-1:0] byte_address;
  logic [DATA_W-1:0] write_data;
  modport source (output valid, req_type, byte_address, write_data, input ready);
  modport sink   (input valid, req_type, byte_address, write_data, output ready);
endinterface

interface emru_rsp_if;
  import emru_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

interface emru_cfg_if;
  logic valid;
  logic ready;
  logic force_success;
  modport source (output valid, force_success, input ready);
  modport sink   (input valid, force_success, output ready);
endinterface

// ===== hw/rtl/emru_regs.sv =====
// ----------------------------------------------------------------------------
// emru_regs
// Register file, message assembly and reply build; one access per cycle.
// ----------------------------------------------------------------------------
module emru_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_fire,
  input  emru_pkg::emru_req_t req_item,
  input  logic                cfg_fire,
  input  logic                cfg_force,
  output emru_pkg::emru_rsp_t rsp_item
);
  import emru_pkg::*;

  logic                             force_success;
  logic [N_CTRL-1:0][DATA_W-1:0]    control_regs;
  logic [TX_WORDS-1:0][DATA_W-1:0]  transmit_words;
  logic [CNT_W-1:0]                 words_received;
  logic [CNT_W-1:0]                 words_expected;
  logic [DATA_W-1:0]                reply_hdr;
  logic [7:0]                       reply_status;
  logic [RX_WORDS-1:0]              reply_full;

  logic [ADDR_W-1:0]   addr;
  logic [DATA_W-1:0]   wdata;
  logic                is_wr;
  logic                in_tx;
  logic                in_rx;
  logic [ADDR_W-1:0]   tx_off;
  logic [ADDR_W-1:0]   rx_off;
  logic [TX_IDX_W-1:0] tx_rd_idx;
  logic [RX_IDX_W-1:0] rx_idx;
  logic [TX_IDX_W-1:0] tx_wr_idx;
  logic                ctrl_hit;
  logic [CTRL_IDX_W-1:0] ctrl_idx;
  logic [7:0]          size_byte;
  logic [CNT_W-1:0]    size_eff;
  logic [CNT_W-1:0]    exp_eff;
  logic [CNT_W-1:0]    recv_inc;
  logic                msg_done;
  logic [DATA_W-1:0]   hdr_word;
  logic [7:0]          cmd;
  logic [CNT_W-1:0]    rsize;
  logic [RX_WORDS-1:0] full_new;
  logic [DATA_W-1:0]   rd_data;
  logic                tx_wr;
  logic                rx_rd;

  // Address decode
  assign addr      = req_item.byte_address;
  assign wdata     = req_item.write_data;
  assign is_wr     = (req_item.req_type == REQ_WRITE);
  assign in_tx     = (addr >= TX_BASE) && (addr < TX_END);
  assign in_rx     = (addr >= RX_BASE) && (addr < RX_END);
  assign tx_off    = addr - TX_BASE;
  assign rx_off    = addr - RX_BASE;
  assign tx_rd_idx = tx_off[TX_IDX_W+1:2];
  assign rx_idx    = rx_off[RX_IDX_W+1:2];
  assign tx_wr_idx = words_received[TX_IDX_W-1:0];
  assign tx_wr     = req_fire && is_wr && in_tx;
  assign rx_rd     = req_fire && !is_wr && in_rx;

  always_comb begin
    ctrl_hit = 1'b0;
    ctrl_idx = '0;
    for (int i = 0; i < N_CTRL; i++) begin
      if (addr == CTRL_ADDR[i]) begin
        ctrl_hit = 1'b1;
        ctrl_idx = CTRL_IDX_W'(i);
      end
    end
  end

  // Message length and completion
  assign size_byte = wdata[15:8];
  assign size_eff  = ((size_byte == 8'd0) || (size_byte > 8'(TX_WORDS))) ?
                     CNT_W'(1) : size_byte[CNT_W-1:0];
  assign exp_eff   = (words_received == '0) ? size_eff : words_expected;
  assign recv_inc  = words_received + CNT_W'(1);
  assign msg_done  = (recv_inc >= exp_eff);

  // Reply header from the first message word, which may arrive right now
  assign hdr_word = (words_received == '0) ? wdata : transmit_words[0];
  assign cmd      = hdr_word[23:16];
  assign rsize    = ((cmd == CMD_C5) && (RX_WORDS >= 3)) ? CNT_W'(3) : CNT_W'(2);

  always_comb begin
    for (int i = 0; i < RX_WORDS; i++) begin
      full_new[i] = (CNT_W'(i) < rsize);
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      force_success  <= 1'b0;
      control_regs   <= '0;
      transmit_words <= '0;
      words_received <= '0;
      words_expected <= '0;
      reply_hdr      <= '0;
      reply_status   <= '0;
      reply_full     <= '0;
    end else begin
      if (cfg_fire) begin
        force_success <= cfg_force;
      end
      if (tx_wr) begin
        transmit_words[tx_wr_idx] <= wdata;
        if (msg_done) begin
          words_received <= '0;
          words_expected <= '0;
          reply_hdr      <= {HDR_TAG, cmd, 4'd0, rsize, hdr_word[7:0]};
          reply_status   <= (cmd_known(cmd) || force_success) ? ST_OK : ST_FAIL;
          reply_full     <= full_new;
        end else begin
          words_received <= recv_inc;
          words_expected <= exp_eff;
        end
      end else if (req_fire && is_wr && ctrl_hit) begin
        control_regs[ctrl_idx] <= wdata;
      end
      if (rx_rd) begin
        reply_full[rx_idx] <= 1'b0;
      end
    end
  end

  // Read mux
  always_comb begin
    rd_data = '0;
    if (in_rx) begin
      if (rx_idx == RX_IDX_W'(0)) begin
        rd_data = reply_hdr;
      end else if (rx_idx == RX_IDX_W'(1)) begin
        rd_data = {24'd0, reply_status};
      end
    end else if (in_tx) begin
      rd_data = transmit_words[tx_rd_idx];
    end else if (ctrl_hit) begin
      rd_data = control_regs[ctrl_idx];
    end else if (addr == ADDR_VERSION) begin
      rd_data = VER_WORD;
    end else if (addr == ADDR_SIZES) begin
      rd_data = SIZES_WORD;
    end else if (addr == ADDR_TSR) begin
      rd_data = TSR_WORD;
    end else if (addr == ADDR_RSR) begin
      rd_data = DATA_W'(reply_full);
    end
  end

  assign rsp_item.valid     = req_fire;
  assign rsp_item.read_data = is_wr ? '0 : rd_data;

endmodule

// ===== hw/rtl/emru_out_buf.sv =====
// ----------------------------------------------------------------------------
// emru_out_buf
// Two-entry response buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module emru_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  emru_pkg::emru_rsp_t push,
  output logic                ready,
  emru_rsp_if.source          rsp
);
  import emru_pkg::*;

  logic              main_valid;
  logic [DATA_W-1:0] main_data;
  logic              skid_valid;
  logic [DATA_W-1:0] skid_data;
  logic              pop;

  assign ready         = !skid_valid;
  assign pop           = main_valid && rsp.ready;
  assign rsp.valid     = main_valid;
  assign rsp.read_data = main_data;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push.valid) begin
      if (main_valid && !pop) begin
        skid_data <= push.read_data;
      end else begin
        main_data <= push.read_data;
      end
    end
  end

endmodule

// ===== hw/rtl/enclave_mailbox_reply_unit.sv =====
// ----------------------------------------------------------------------------
// enclave_mailbox_reply_unit
// Mailbox register window with message assembly and automatic reply.
// ----------------------------------------------------------------------------
// Usage:
//   req : one 32-bit bus read or write per transfer (req_type, byte_address,
//         write_data). Every request produces exactly one response.
//   rsp : read_data for reads, zero for writes and unmapped offsets.
//   cfg : writes force_success; always ready, meant for use while idle.
// Responses are registered: a response goes to the output register, or to
// the skid register when the output waits. Throughput is one request per
// cycle while responses are taken, set by the single decode/update pass
// in emru_regs; the response side holds two entries, so a request is still
// taken while one response waits. If the receiver stalls, the second entry
// fills and req.ready drops until a response is taken.
// Reset (rst, synchronous) clears every register in emru_regs, message state
// and full bits and empties the response buffer; no clearing pass follows.
// ----------------------------------------------------------------------------
module enclave_mailbox_reply_unit (
  input  logic        clk,
  input  logic        rst,
  emru_req_if.sink    req,
  emru_rsp_if.source  rsp,
  emru_cfg_if.sink    cfg
);
  import emru_pkg::*;

  emru_req_t req_item;
  emru_rsp_t rsp_item;
  logic      buf_ready;
  logic      req_fire;
  logic      cfg_fire;

  // Handshakes
  assign req.ready = buf_ready;
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && buf_ready;
  assign cfg_fire  = cfg.valid;

  assign req_item.req_type     = req.req_type;
  assign req_item.byte_address = req.byte_address;
  assign req_item.write_data   = req.write_data;

  emru_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .req_fire  (req_fire),
    .req_item  (req_item),
    .cfg_fire  (cfg_fire),
    .cfg_force (cfg.force_success),
    .rsp_item  (rsp_item)
  );

  emru_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .push  (rsp_item),
    .ready (buf_ready),
    .rsp   (rsp)
  );

endmodule

// ===== hw/rtl/emru_checker.sv =====
// ----------------------------------------------------------------------------
// emru_checker
// Port-level checks for the mailbox reply unit, bound to the top level.
// ----------------------------------------------------------------------------
module emru_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      req_type,
  input logic [emru_pkg::ADDR_W-1:0] byte_address,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [emru_pkg::DATA_W-1:0] read_data
);
  import emru_pkg::*;

  logic req_fire;
  assign req_fire = req_valid && req_ready;

  // Response is valid in the cycle after a request taken with an empty output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !rsp_valid) |=> rsp_valid)
    else $error("response missing one cycle after request");

  // Version read returns the fixed version word
  a_version: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !rsp_valid && req_type == REQ_READ && byte_address == ADDR_VERSION)
    |=> (read_data == VER_WORD))
    else $error("version read returned wrong data");

  // Writes answer with zero; checked for writes taken with an empty output
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !rsp_valid && req_type == REQ_WRITE) |=> (read_data == '0))
    else $error("write response not zero");

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(read_data)))
    else $error("stalled response changed");

endmodule

bind enclave_mailbox_reply_unit emru_checker u_emru_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_type     (req.req_type),
  .byte_address (req.byte_address),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .read_data    (rsp.read_data)
);
